/* hdl/hbsf_pkg.sv */
// Package for the hierarchical bitmap slot finder.
// Holds the request/response structs, operation and status codes, size parameters and register indices.
// No dependencies.
package hbsf_pkg;

   localparam int MaxLeafBits = 4096;
   localparam int MaxPlanes   = 2;
   localparam int WordBits    = 64;

   localparam int LeafCountW  = 13;
   localparam int PlaneCountW = 2;

   localparam logic [2:0] OP_SET        = 3'd0;
   localparam logic [2:0] OP_CLEAR      = 3'd1;
   localparam logic [2:0] OP_FIND_WRAP  = 3'd2;
   localparam logic [2:0] OP_FIND_NEXT  = 3'd3;
   localparam logic [2:0] OP_FILL       = 3'd4;
   localparam logic [2:0] OP_CLEAR_ALL  = 3'd5;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_NONE    = 2'd1;
   localparam logic [1:0] ST_REFUSED = 2'd2;

   localparam int REG_LEAF_COUNT  = 0;
   localparam int REG_PLANE_COUNT = 1;

   typedef struct packed {
      logic [2:0]  operation;
      logic [11:0] slot_index;
      logic        plane;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] found_index;
   } rsp_type;

endpackage

/* hdl/hbsf_lzc.sv */
// Lowest-set-bit finder for one word.
// Depends on nothing but its parameter; found is low when the word is zero.
module hbsf_lzc #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0]         word,
   output logic                     found,
   output logic [$clog2(WIDTH)-1:0] pos
);
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (word[i]) begin
            found = 1'b1;
            pos   = ($clog2(WIDTH))'(i);
         end
      end
   end
endmodule

/* hdl/hierarchical_bitmap_slot_finder_core.sv */
// Hierarchical bitmap slot finder: two-level bitmap with summary word per plane.
// Set/clear update one word; find-next searches from the hint, then via the summary;
// find-with-wrap takes a 12-step remainder of the hint by the leaf count, searches
// likewise, may wrap once to 0; fill/clear plane write each word. One request at a
// time; busy is high until the strobe cycle. Reset, and any register write, clears
// all Depth memory words with busy high. The receiver cannot stall the response.
module hierarchical_bitmap_slot_finder_core #(
   parameter int MAX_LEAF_BITS = hbsf_pkg::MaxLeafBits,
   parameter int MAX_PLANES    = hbsf_pkg::MaxPlanes,
   parameter int WORD_BITS     = hbsf_pkg::WordBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hbsf_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output hbsf_pkg::rsp_type    rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import hbsf_pkg::*;

   localparam int LeafWords = (MAX_LEAF_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int SumBits   = (LeafWords > 1) ? LeafWords : 2;
   localparam int BitW      = $clog2(WORD_BITS);
   localparam int WordW     = (LeafWords > 1) ? $clog2(LeafWords) : 1;
   localparam int PlaneW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
   localparam int Depth     = MAX_PLANES * LeafWords;
   localparam int AddrW     = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int LzW       = (WORD_BITS > SumBits) ? WORD_BITS : SumBits;
   localparam int ModW      = LeafCountW + 11;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_MOD, S_READ, S_EVAL, S_SUMS, S_READ2, S_EVAL2, S_FILL, S_RESP
   } state_type;

   state_type            state_ff;
   logic [AddrW-1:0]     sweep_ff;
   logic [LeafCountW-1:0] leaf_count_ff;
   logic [PlaneCountW-1:0] plane_count_ff;
   logic [SumBits-1:0]   summary_ff [MAX_PLANES];
   logic [WORD_BITS-1:0] mem [Depth];
   logic [WORD_BITS-1:0] rd_ff;
   logic [2:0]           op_ff;
   logic [11:0]          start_ff;
   logic [PlaneW-1:0]    plane_ff;
   logic                 wrapped_ff;
   logic [WordW-1:0]     word_ff;
   logic [3:0]           mod_step_ff;
   logic [1:0]           status_ff;
   logic [11:0]          found_ff;
   logic                 rsp_valid_ff;

   logic                 wr_en;
   logic [AddrW-1:0]     wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [AddrW-1:0]     rd_addr;

   logic [LzW-1:0]       lz_word;
   logic                 lz_found;
   logic [$clog2(LzW)-1:0] lz_pos;

   logic                 cfg_wr;
   logic [LeafCountW-1:0] lc_sat;
   logic [PlaneCountW-1:0] pc_sat;
   logic [WordW:0]       used_words;
   logic [BitW-1:0]      bit_sel;
   logic [WORD_BITS-1:0] bit_mask;
   logic [WORD_BITS-1:0] fill_word;
   logic [LeafCountW-1:0] fill_lo;
   logic [LeafCountW-1:0] cand;
   logic [LeafCountW-1:0] req_idx_ext;
   logic [ModW-1:0]      mod_sub;
   logic                 req_ok;

   hbsf_lzc #(.WIDTH(LzW)) u_lzc (.word(lz_word), .found(lz_found), .pos(lz_pos));

   assign pready    = 1'b1;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = '{status: status_ff, found_index: found_ff};
   assign cfg_wr    = psel && penable && pwrite;

   always_comb begin
      prdata = '0;
      case (paddr[2])
         1'b0:    prdata = 32'(leaf_count_ff);
         default: prdata = 32'(plane_count_ff);
      endcase
   end

   always_comb begin
      lc_sat = (pwdata[LeafCountW-1:0] > LeafCountW'(MAX_LEAF_BITS)) ?
               LeafCountW'(MAX_LEAF_BITS) : pwdata[LeafCountW-1:0];
      pc_sat = (32'(pwdata[PlaneCountW-1:0]) > 32'(MAX_PLANES)) ?
               PlaneCountW'(MAX_PLANES) : pwdata[PlaneCountW-1:0];
      used_words  = (WordW+1)'((32'(leaf_count_ff) + WORD_BITS - 1) >> BitW);
      req_idx_ext = LeafCountW'(req_data.slot_index);
      mod_sub     = ModW'(leaf_count_ff) << mod_step_ff;
      req_ok = (leaf_count_ff != '0) && (plane_count_ff != '0) &&
               (32'(req_data.plane) < 32'(plane_count_ff)) &&
               (req_data.operation <= OP_CLEAR_ALL);
   end

   // word index and bit within start position
   logic [WordW-1:0] word_sel;
   always_comb begin
      word_sel   = WordW'(32'(start_ff) >> BitW);
      bit_sel    = start_ff[BitW-1:0];
      bit_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;
      fill_lo    = LeafCountW'(32'(word_ff) << BitW);
      if (fill_lo >= leaf_count_ff)
         fill_word = '0;
      else if (32'(leaf_count_ff - fill_lo) >= WORD_BITS)
         fill_word = '1;
      else
         fill_word = ({{(WORD_BITS-1){1'b0}}, 1'b1} <<
                      BitW'(leaf_count_ff - fill_lo)) - 1'b1;
   end

   always_comb begin
      lz_word = '0;
      cand    = '0;
      rd_addr = AddrW'(32'(plane_ff) * LeafWords + 32'(word_sel));
      case (state_ff)
         S_EVAL: lz_word = LzW'(rd_ff & ~(bit_mask - 1'b1));
         S_SUMS: lz_word = LzW'(summary_ff[plane_ff] &
                           ~((SumBits'(1) << ((WordW+1)'(word_sel) + 1'b1)) - 1'b1) &
                           ((SumBits'(1) << used_words) - 1'b1));
         S_EVAL2: lz_word = LzW'(rd_ff);
         default: lz_word = '0;
      endcase
      if (state_ff == S_READ2)
         rd_addr = AddrW'(32'(plane_ff) * LeafWords + 32'(word_ff));
      if (state_ff == S_EVAL)
         cand = LeafCountW'((32'(word_sel) << BitW) + 32'(lz_pos));
      else
         cand = LeafCountW'((32'(word_ff) << BitW) + 32'(lz_pos));
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AddrW'(32'(plane_ff) * LeafWords + 32'(word_sel));
      wr_data = rd_ff;
      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
            wr_data = '0;
         end
         S_EVAL: begin
            if (op_ff == OP_SET && status_ff == ST_DONE) begin
               wr_en = !(|(rd_ff & bit_mask));
               wr_data = rd_ff | bit_mask;
            end else if (op_ff == OP_CLEAR && status_ff == ST_DONE) begin
               wr_en = |(rd_ff & bit_mask);
               wr_data = rd_ff & ~bit_mask;
            end
         end
         S_FILL: begin
            wr_en   = 1'b1;
            wr_addr = AddrW'(32'(plane_ff) * LeafWords + 32'(word_ff));
            wr_data = (op_ff == OP_FILL) ? fill_word : '0;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         state_ff       <= S_INIT;
         sweep_ff       <= '0;
         leaf_count_ff  <= '0;
         plane_count_ff <= '0;
         for (int p = 0; p < MAX_PLANES; p++) summary_ff[p] <= '0;
      end else if (cfg_wr) begin
         rsp_valid_ff <= 1'b0;
         if (paddr[2] == 1'(REG_LEAF_COUNT)) leaf_count_ff <= lc_sat;
         else plane_count_ff <= pc_sat;
         for (int p = 0; p < MAX_PLANES; p++) summary_ff[p] <= '0;
         sweep_ff <= '0;
         state_ff <= S_INIT;
      end else begin
         rsp_valid_ff <= (state_ff == S_RESP);
         case (state_ff)
            S_INIT: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (32'(sweep_ff) == Depth - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  op_ff      <= req_data.operation;
                  plane_ff   <= PlaneW'(req_data.plane);
                  wrapped_ff <= 1'b0;
                  found_ff   <= '0;
                  word_ff    <= '0;
                  start_ff   <= req_data.slot_index;
                  if (req_ok) begin
                     case (req_data.operation)
                        OP_SET, OP_CLEAR, OP_FIND_NEXT: begin
                           if (req_idx_ext < leaf_count_ff) begin
                              status_ff <= ST_DONE;
                              state_ff  <= S_READ;
                           end else begin
                              status_ff <= ST_REFUSED;
                              state_ff  <= S_RESP;
                           end
                        end
                        OP_FIND_WRAP: begin
                           status_ff   <= ST_DONE;
                           mod_step_ff <= 4'd11;
                           state_ff    <= S_MOD;
                        end
                        default: begin
                           status_ff <= ST_DONE;
                           state_ff  <= S_FILL;
                        end
                     endcase
                  end else begin
                     status_ff <= ST_REFUSED;
                     state_ff  <= S_RESP;
                  end
               end
            end
            S_MOD: begin
               // reduce wrap hint one restoring step per cycle
               if (ModW'(start_ff) >= mod_sub)
                  start_ff <= start_ff - mod_sub[11:0];
               if (mod_step_ff == '0) state_ff <= S_READ;
               else mod_step_ff <= mod_step_ff - 1'b1;
            end
            S_READ: state_ff <= S_EVAL;
            S_EVAL: begin
               if (op_ff == OP_SET) begin
                  state_ff <= S_RESP;
                  if (|(rd_ff & bit_mask)) status_ff <= ST_NONE;
                  else summary_ff[plane_ff][word_sel] <= 1'b1;
               end else if (op_ff == OP_CLEAR) begin
                  state_ff <= S_RESP;
                  if (!(|(rd_ff & bit_mask))) status_ff <= ST_NONE;
                  else if ((rd_ff & ~bit_mask) == '0)
                     summary_ff[plane_ff][word_sel] <= 1'b0;
               end else if (lz_found && cand < leaf_count_ff) begin
                  state_ff <= S_RESP;
                  found_ff <= 12'(cand);
               end else if (lz_found && op_ff == OP_FIND_WRAP && !wrapped_ff &&
                            start_ff != '0) begin
                  start_ff   <= '0;
                  wrapped_ff <= 1'b1;
                  state_ff   <= S_READ;
               end else if (lz_found) begin
                  status_ff <= ST_NONE;
                  state_ff  <= S_RESP;
               end else begin
                  state_ff <= S_SUMS;
               end
            end
            S_SUMS: begin
               if (lz_found) begin
                  word_ff  <= WordW'(lz_pos);
                  state_ff <= S_READ2;
               end else if (op_ff == OP_FIND_WRAP && !wrapped_ff && start_ff != '0) begin
                  start_ff   <= '0;
                  wrapped_ff <= 1'b1;
                  state_ff   <= S_READ;
               end else begin
                  status_ff <= ST_NONE;
                  state_ff  <= S_RESP;
               end
            end
            S_READ2: state_ff <= S_EVAL2;
            S_EVAL2: begin
               if (lz_found && cand < leaf_count_ff) begin
                  found_ff <= 12'(cand);
                  state_ff <= S_RESP;
               end else if (op_ff == OP_FIND_WRAP && !wrapped_ff && start_ff != '0) begin
                  start_ff   <= '0;
                  wrapped_ff <= 1'b1;
                  state_ff   <= S_READ;
               end else begin
                  status_ff <= ST_NONE;
                  state_ff  <= S_RESP;
               end
            end
            S_FILL: begin
               summary_ff[plane_ff][word_ff] <= (op_ff == OP_FILL) && (fill_word != '0);
               word_ff <= word_ff + 1'b1;
               if (32'(word_ff) == LeafWords - 1) state_ff <= S_RESP;
            end
            S_RESP: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid)) else $error("back-to-back responses");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_DONE && rsp_data.found_index != '0 |->
      (op_ff == OP_FIND_WRAP || op_ff == OP_FIND_NEXT)) else $error("stray found_index");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3) else $error("bad status");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(busy, 1) || $past(state_ff) == S_RESP) else $error("response order");
endmodule
